>>> design/rsa_modular_exponentiation_defines.svh
// Assertion macros shared by the modular exponentiation RTL.
// Each macro expects clk and rst_n in scope.
`ifndef RSA_MODULAR_EXPONENTIATION_DEFINES_SVH
`define RSA_MODULAR_EXPONENTIATION_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define RSAME_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define RSAME_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rsame_pkg.sv
`timescale 1ns / 1ps
package rsame_pkg;

  // Operand width of message, exponent, modulus and result
  localparam int VALUE_BITS = 16;
  // Bit counter width for one serial multiplication
  localparam int CNT_W = $clog2(VALUE_BITS);

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 1'b1;

  typedef logic [VALUE_BITS-1:0] value_t;

  localparam value_t EXPONENT_RST = value_t'(5);
  localparam value_t MODULUS_RST  = value_t'(1);

  // Request to the serial modular multiplier
  typedef struct packed {
    logic   go;
    value_t a;
    value_t b;
    value_t m;
  } mm_req_t;

  // Response from the serial modular multiplier
  typedef struct packed {
    logic   done;
    value_t p;
  } mm_rsp_t;

  // (x + y) mod m for x, y < m; never overflows the operand width
  function automatic value_t add_mod(value_t x, value_t y, value_t m);
    value_t room;
    room = m - y;
    if (x >= room) begin
      return x - room;
    end
    return x + y;
  endfunction

endpackage

>>> design/rsame_modmul.sv
`timescale 1ns / 1ps
`include "rsa_modular_exponentiation_defines.svh"
// Bit-serial modular multiplier: walks b from its top bit, one bit per cycle,
// doubling the accumulator and adding a where the bit is set.
module rsame_modmul (
  input  logic              clk,
  input  logic              rst_n,
  input  rsame_pkg::mm_req_t req,
  output rsame_pkg::mm_rsp_t rsp
);

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [rsame_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  rsame_pkg::value_t       acc_r, acc_nxt;
  rsame_pkg::value_t       a_r, a_nxt;
  rsame_pkg::value_t       b_r, b_nxt;
  rsame_pkg::value_t       m_r, m_nxt;
  rsame_pkg::value_t       dbl;

  // Double, then add a if the current multiplier bit is set
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    m_nxt    = m_r;
    dbl      = rsame_pkg::add_mod(acc_r, acc_r, m_r);
    if (req.go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = rsame_pkg::CNT_W'(rsame_pkg::VALUE_BITS - 1);
      acc_nxt  = '0;
      a_nxt    = req.a;
      b_nxt    = req.b;
      m_nxt    = req.m;
    end else if (busy_r) begin
      acc_nxt = b_r[rsame_pkg::VALUE_BITS-1] ? rsame_pkg::add_mod(dbl, a_r, m_r) : dbl;
      b_nxt   = {b_r[rsame_pkg::VALUE_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    m_r   <= m_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

  `RSAME_ASSERT_IMP(a_mm_no_overlap, req.go, !busy_r, "multiplier restarted while busy")
  `RSAME_ASSERT_IMP(a_mm_acc_reduced, busy_r, acc_r < m_r, "accumulator left modulus range")

endmodule

>>> design/rsa_modular_exponentiation.sv
`timescale 1ns / 1ps
`include "rsa_modular_exponentiation_defines.svh"
// Channel   | Ports                               | Handshake
// ----------+-------------------------------------+------------------------------
// input     | in_message_value                    | start high while busy low
// result    | out_cipher_value                    | out_valid strobe, one cycle
// config    | cfg_we, cfg_index, cfg_data         | cfg_we high, no wait
//
// Each modular product runs through one bit-serial multiplier, one operand bit
// per cycle, from issue through done. An item first reduces the message, then
// for each exponent bit up to the highest set one issues a square (bit clear)
// or a multiply followed by a square (bit set), and then strobes the result.
// A zero exponent or zero modulus strobes its result in the cycle after accept.
// Reset is synchronous with no clearing pass; the receiver cannot stall results.
module rsa_modular_exponentiation (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [rsame_pkg::VALUE_BITS-1:0]    in_message_value,
  output logic                                out_valid,
  output logic [rsame_pkg::VALUE_BITS-1:0]    out_cipher_value,
  input  logic                                cfg_we,
  input  logic [rsame_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rsame_pkg::VALUE_BITS-1:0]    cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_STEP = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_SQR  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  rsame_pkg::value_t   exp_cfg_r, mod_cfg_r;
  rsame_pkg::value_t   exp_r, exp_nxt;
  rsame_pkg::value_t   acc_r, acc_nxt;
  rsame_pkg::value_t   base_r, base_nxt;
  rsame_pkg::mm_req_t  req_r, req_nxt;
  rsame_pkg::mm_rsp_t  rsp;
  logic                out_valid_r, out_valid_nxt;
  rsame_pkg::value_t   out_cipher_value_r, out_cipher_value_nxt;
  rsame_pkg::value_t   one_m;
  logic                accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_cfg_r <= rsame_pkg::EXPONENT_RST;
      mod_cfg_r <= rsame_pkg::MODULUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rsame_pkg::CFG_EXPONENT: exp_cfg_r <= cfg_data;
        rsame_pkg::CFG_MODULUS:  mod_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // 1 mod n
  assign one_m  = (mod_cfg_r == rsame_pkg::value_t'(1)) ? '0 : rsame_pkg::value_t'(1);
  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Square-and-multiply sequencer, exponent shifted out one bit per square
  always_comb begin
    state_nxt            = state_r;
    exp_nxt              = exp_r;
    acc_nxt              = acc_r;
    base_nxt             = base_r;
    req_nxt              = req_r;
    req_nxt.go           = 1'b0;
    req_nxt.m            = mod_cfg_r;
    out_valid_nxt        = 1'b0;
    out_cipher_value_nxt = out_cipher_value_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (exp_cfg_r == '0) begin
            out_valid_nxt        = 1'b1;
            out_cipher_value_nxt = rsame_pkg::value_t'(1);
          end else if (mod_cfg_r == '0) begin
            out_valid_nxt        = 1'b1;
            out_cipher_value_nxt = '0;
          end else begin
            // reduce the message: (1 mod n) * m mod n
            exp_nxt    = exp_cfg_r;
            req_nxt.go = 1'b1;
            req_nxt.a  = one_m;
            req_nxt.b  = in_message_value;
            state_nxt  = S_RED;
          end
        end
      end
      S_RED: begin
        if (rsp.done) begin
          base_nxt  = rsp.p;
          acc_nxt   = one_m;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (exp_r == '0) begin
          out_valid_nxt        = 1'b1;
          out_cipher_value_nxt = acc_r;
          state_nxt            = S_IDLE;
        end else if (exp_r[0]) begin
          req_nxt.go = 1'b1;
          req_nxt.a  = acc_r;
          req_nxt.b  = base_r;
          state_nxt  = S_MUL;
        end else begin
          req_nxt.go = 1'b1;
          req_nxt.a  = base_r;
          req_nxt.b  = base_r;
          state_nxt  = S_SQR;
        end
      end
      S_MUL: begin
        if (rsp.done) begin
          acc_nxt    = rsp.p;
          req_nxt.go = 1'b1;
          req_nxt.a  = base_r;
          req_nxt.b  = base_r;
          state_nxt  = S_SQR;
        end
      end
      S_SQR: begin
        if (rsp.done) begin
          base_nxt  = rsp.p;
          exp_nxt   = {1'b0, exp_r[rsame_pkg::VALUE_BITS-1:1]};
          state_nxt = S_STEP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state and multiplier request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      req_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      req_r       <= req_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    exp_r              <= exp_nxt;
    acc_r              <= acc_nxt;
    base_r             <= base_nxt;
    out_cipher_value_r <= out_cipher_value_nxt;
  end

  rsame_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_r),
    .rsp   (rsp)
  );

  assign out_valid        = out_valid_r;
  assign out_cipher_value = out_cipher_value_r;

  `RSAME_ASSERT_NXT(a_step_done_strobes, (state_r == S_STEP) && (exp_r == '0), out_valid_r,
    "finished item not strobed")
  `RSAME_ASSERT_IMP(a_mult_has_exp, (state_r == S_MUL) || (state_r == S_SQR), exp_r != '0,
    "multiplication issued with exponent exhausted")

endmodule
